FILE: sv/confusion_matrix_metrics_defines.svh
// ---------------------------------------------------------------------------
// Confusion matrix metrics assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef CONFUSION_MATRIX_METRICS_DEFINES_SVH
`define CONFUSION_MATRIX_METRICS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CMM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cmm_pkg.sv
// ---------------------------------------------------------------------------
// Confusion matrix metrics package
// Widths, sizes and command codes shared by the block's modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmm_pkg;

  localparam int NUM_CLASSES = 8;
  localparam int CLS_W       = 3;
  localparam int CNT_W       = 16;
  localparam int SUM_W       = 32;
  localparam int FRAC_BITS   = 16;
  localparam int RATIO_W     = FRAC_BITS + 1;
  localparam int KAPPA_W     = FRAC_BITS + 2;
  localparam int DTOT_W      = SUM_W + CLS_W;
  localparam int PROD_W      = DTOT_W + SUM_W;
  localparam int DIV_NUM_W   = PROD_W;
  localparam int DIV_DEN_W   = 2 * SUM_W;
  localparam int DIV_CNT_W   = $clog2(FRAC_BITS + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

endpackage

FILE: sv/cmm_div.sv
// ---------------------------------------------------------------------------
// Confusion matrix metrics fraction divider
// Restoring divider, one quotient bit per cycle: floor(num * 2^F / den),
// zero for a zero denominator, saturated at one when num >= den.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cmm_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [cmm_pkg::DIV_DEN_W-1:0] den_i,
  output logic                          done_o,
  output logic [cmm_pkg::RATIO_W-1:0]   quo_o
);
  import cmm_pkg::*;

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHECK,
    D_RUN
  } div_state_e;

  div_state_e             state_q;
  logic [DIV_NUM_W-1:0]   num_q;
  logic [DIV_DEN_W-1:0]   den_q;
  logic [DIV_DEN_W-1:0]   rem_q;
  logic [FRAC_BITS-1:0]   q_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   done_q;
  logic [RATIO_W-1:0]     quo_q;

  logic [DIV_DEN_W:0]     trial;
  logic                   trial_ge;

  assign trial    = {rem_q, 1'b0};
  assign trial_ge = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            num_q   <= num_i;
            den_q   <= den_i;
            state_q <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (den_q == '0) begin
            quo_q   <= '0;
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else if (num_q >= DIV_NUM_W'(den_q)) begin
            quo_q   <= RATIO_W'(1) << FRAC_BITS;
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else begin
            rem_q   <= num_q[DIV_DEN_W-1:0];
            q_q     <= '0;
            cnt_q   <= DIV_CNT_W'(FRAC_BITS);
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= trial_ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
          q_q   <= {q_q[FRAC_BITS-2:0], trial_ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == DIV_CNT_W'(1)) begin
            quo_q   <= {1'b0, q_q[FRAC_BITS-2:0], trial_ge};
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: sv/confusion_matrix_metrics.sv
// ---------------------------------------------------------------------------
// Confusion matrix metrics
// Keeps row, column and diagonal sums of a confusion matrix and, on a compute
// beat, emits per-class counts and ratios plus accuracy and Cohen's kappa.
// ---------------------------------------------------------------------------
// Clear and add beats leave the block idle, so they do not stall the input. A
// compute beat holds the input stalled while one 35x32 multiplier (a multiply
// and an accumulate step per class for the kappa product sum, then N*N and
// D*N) and one restoring divider (one quotient bit per cycle) work through the
// kappa, the accuracy and five ratios for each class; a ratio ends early when
// its denominator is zero or it saturates, and a result beat is held while the
// output is stalled. Results leave in class order, one beat per class,
// last_class_o set on the final one.
`timescale 1ns / 1ps

`include "confusion_matrix_metrics_defines.svh"

module confusion_matrix_metrics (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        command_i,
  input  logic [cmm_pkg::CLS_W-1:0]         row_index_i,
  input  logic [cmm_pkg::CLS_W-1:0]         col_index_i,
  input  logic [cmm_pkg::CNT_W-1:0]         cell_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cmm_pkg::CLS_W-1:0]         class_index_o,
  output logic [cmm_pkg::SUM_W-1:0]         true_pos_o,
  output logic [cmm_pkg::SUM_W-1:0]         false_pos_o,
  output logic [cmm_pkg::SUM_W-1:0]         false_neg_o,
  output logic [cmm_pkg::RATIO_W-1:0]       recall_ratio_o,
  output logic [cmm_pkg::RATIO_W-1:0]       precision_ratio_o,
  output logic [cmm_pkg::RATIO_W-1:0]       f_score_o,
  output logic [cmm_pkg::RATIO_W-1:0]       specificity_ratio_o,
  output logic [cmm_pkg::RATIO_W-1:0]       neg_pred_value_o,
  output logic [cmm_pkg::RATIO_W-1:0]       overall_accuracy_o,
  output logic signed [cmm_pkg::KAPPA_W-1:0] kappa_value_o,
  output logic                              last_class_o
);
  import cmm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_MUL,
    ST_SUM_ACC,
    ST_NN_MUL,
    ST_DN_MUL,
    ST_KAP_PREP,
    ST_KAP_WAIT,
    ST_ACC_START,
    ST_ACC_WAIT,
    ST_CLS_DIFF,
    ST_CLS_TN1,
    ST_CLS_TN2,
    ST_CLS_START,
    ST_CLS_WAIT,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    M_RECALL,
    M_PREC,
    M_F1,
    M_SPEC,
    M_NPV
  } metric_e;

  state_e                   state_q;
  metric_e                  sel_q;
  logic [CLS_W-1:0]         k_q;

  logic [SUM_W-1:0]         row_sums_q  [NUM_CLASSES];
  logic [SUM_W-1:0]         col_sums_q  [NUM_CLASSES];
  logic [SUM_W-1:0]         diag_sums_q [NUM_CLASSES];
  logic [SUM_W-1:0]         total_q;

  logic [PROD_W-1:0]        prod_q;
  logic [PROD_W-1:0]        s_q;
  logic [DTOT_W-1:0]        dtot_q;
  logic [DIV_DEN_W-1:0]     nn_q;
  logic                     kap_neg_q;

  logic [SUM_W-1:0]         tp_q, fp_q, fn_q, tn_q;
  logic [RATIO_W-1:0]       recall_q, prec_q, f1_q, spec_q, npv_q, acc_q;
  logic signed [KAPPA_W-1:0] kap_q;
  logic                     out_valid_q;

  logic                     div_start_q;
  logic [DIV_NUM_W-1:0]     div_num_q;
  logic [DIV_DEN_W-1:0]     div_den_q;
  logic                     div_done;
  logic [RATIO_W-1:0]       div_quo;

  logic [CLS_W-1:0]         row_addr, col_addr;
  logic [SUM_W-1:0]         row_rd, col_rd, diag_rd;
  logic [DTOT_W-1:0]        mul_a;
  logic [SUM_W-1:0]         mul_b;
  logic [PROD_W-1:0]        prod_d;
  logic                     idx_ok;
  logic [SUM_W:0]           row_add, col_add, diag_add, tot_add;
  logic [DIV_NUM_W-1:0]     cls_num;
  logic [DIV_DEN_W-1:0]     cls_den;
  logic                     in_accept;

  function automatic logic [SUM_W-1:0] floor_sub(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] r;
    r = (a > b) ? a - b : '0;
    return r;
  endfunction

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign row_addr = (state_q == ST_IDLE) ? row_index_i : k_q;
  assign col_addr = (state_q == ST_IDLE) ? col_index_i : k_q;
  assign row_rd   = row_sums_q[row_addr];
  assign col_rd   = col_sums_q[col_addr];
  assign diag_rd  = diag_sums_q[row_addr];

  assign idx_ok = ({1'b0, row_index_i} < (CLS_W + 1)'(NUM_CLASSES)) &&
                  ({1'b0, col_index_i} < (CLS_W + 1)'(NUM_CLASSES));
  assign row_add  = {1'b0, row_rd}  + (SUM_W + 1)'(cell_count_i);
  assign col_add  = {1'b0, col_rd}  + (SUM_W + 1)'(cell_count_i);
  assign diag_add = {1'b0, diag_rd} + (SUM_W + 1)'(cell_count_i);
  assign tot_add  = {1'b0, total_q} + (SUM_W + 1)'(cell_count_i);

  always_comb begin
    mul_a = DTOT_W'(row_rd);
    mul_b = col_rd;
    unique case (state_q)
      ST_NN_MUL: begin
        mul_a = DTOT_W'(total_q);
        mul_b = total_q;
      end
      ST_DN_MUL: begin
        mul_a = dtot_q;
        mul_b = total_q;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    cls_num = DIV_NUM_W'(tp_q);
    cls_den = DIV_DEN_W'(tp_q) + DIV_DEN_W'(fn_q);
    unique case (sel_q)
      M_RECALL: ;
      M_PREC:   cls_den = DIV_DEN_W'(tp_q) + DIV_DEN_W'(fp_q);
      M_F1: begin
        cls_num = DIV_NUM_W'(tp_q) << 1;
        cls_den = (DIV_DEN_W'(tp_q) << 1) + DIV_DEN_W'(fp_q) + DIV_DEN_W'(fn_q);
      end
      M_SPEC: begin
        cls_num = DIV_NUM_W'(tn_q);
        cls_den = DIV_DEN_W'(tn_q) + DIV_DEN_W'(fp_q);
      end
      M_NPV: begin
        cls_num = DIV_NUM_W'(tn_q);
        cls_den = DIV_DEN_W'(tn_q) + DIV_DEN_W'(fn_q);
      end
      default: ;
    endcase
  end

  cmm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= M_RECALL;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
      total_q     <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        row_sums_q[i]  <= '0;
        col_sums_q[i]  <= '0;
        diag_sums_q[i] <= '0;
      end
    end else begin
      prod_q      <= prod_d;
      div_start_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            case (command_i)
              CMD_CLEAR: begin
                total_q <= '0;
                for (int i = 0; i < NUM_CLASSES; i++) begin
                  row_sums_q[i]  <= '0;
                  col_sums_q[i]  <= '0;
                  diag_sums_q[i] <= '0;
                end
              end
              CMD_ADD: begin
                if (idx_ok) begin
                  row_sums_q[row_addr] <= row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
                  col_sums_q[col_addr] <= col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
                  if (row_index_i == col_index_i) begin
                    diag_sums_q[row_addr] <= diag_add[SUM_W] ? '1 : diag_add[SUM_W-1:0];
                  end
                  total_q <= tot_add[SUM_W] ? '1 : tot_add[SUM_W-1:0];
                end
              end
              CMD_COMPUTE: begin
                k_q     <= '0;
                s_q     <= '0;
                dtot_q  <= '0;
                state_q <= ST_SUM_MUL;
              end
              default: ;
            endcase
          end
        end
        ST_SUM_MUL: state_q <= ST_SUM_ACC;
        ST_SUM_ACC: begin
          s_q    <= s_q + prod_q;
          dtot_q <= dtot_q + DTOT_W'(diag_rd);
          k_q    <= k_q + 1'b1;
          if (k_q == CLS_W'(NUM_CLASSES - 1)) begin
            state_q <= ST_NN_MUL;
          end else begin
            state_q <= ST_SUM_MUL;
          end
        end
        ST_NN_MUL: state_q <= ST_DN_MUL;
        ST_DN_MUL: begin
          nn_q    <= prod_q[DIV_DEN_W-1:0];
          state_q <= ST_KAP_PREP;
        end
        ST_KAP_PREP: begin
          if (s_q >= PROD_W'(nn_q)) begin
            kap_q   <= '0;
            state_q <= ST_ACC_START;
          end else begin
            kap_neg_q   <= (prod_q < s_q);
            div_num_q   <= (prod_q >= s_q) ? prod_q - s_q : s_q - prod_q;
            div_den_q   <= nn_q - s_q[DIV_DEN_W-1:0];
            div_start_q <= 1'b1;
            state_q     <= ST_KAP_WAIT;
          end
        end
        ST_KAP_WAIT: begin
          if (div_done) begin
            kap_q   <= kap_neg_q ? -$signed(KAPPA_W'(div_quo)) : $signed(KAPPA_W'(div_quo));
            state_q <= ST_ACC_START;
          end
        end
        ST_ACC_START: begin
          div_num_q   <= DIV_NUM_W'(dtot_q);
          div_den_q   <= DIV_DEN_W'(total_q);
          div_start_q <= 1'b1;
          state_q     <= ST_ACC_WAIT;
        end
        ST_ACC_WAIT: begin
          if (div_done) begin
            acc_q   <= div_quo;
            k_q     <= '0;
            state_q <= ST_CLS_DIFF;
          end
        end
        ST_CLS_DIFF: begin
          tp_q    <= diag_rd;
          fp_q    <= floor_sub(row_rd, diag_rd);
          fn_q    <= floor_sub(col_rd, diag_rd);
          state_q <= ST_CLS_TN1;
        end
        ST_CLS_TN1: begin
          tn_q    <= floor_sub(total_q, fn_q);
          state_q <= ST_CLS_TN2;
        end
        ST_CLS_TN2: begin
          tn_q    <= floor_sub(floor_sub(tn_q, fp_q), tp_q);
          sel_q   <= M_RECALL;
          state_q <= ST_CLS_START;
        end
        ST_CLS_START: begin
          div_num_q   <= cls_num;
          div_den_q   <= cls_den;
          div_start_q <= 1'b1;
          state_q     <= ST_CLS_WAIT;
        end
        ST_CLS_WAIT: begin
          if (div_done) begin
            state_q <= ST_CLS_START;
            unique case (sel_q)
              M_RECALL: begin
                recall_q <= div_quo;
                sel_q    <= M_PREC;
              end
              M_PREC: begin
                prec_q <= div_quo;
                sel_q  <= M_F1;
              end
              M_F1: begin
                f1_q  <= div_quo;
                sel_q <= M_SPEC;
              end
              M_SPEC: begin
                spec_q <= div_quo;
                sel_q  <= M_NPV;
              end
              M_NPV: begin
                npv_q       <= div_quo;
                out_valid_q <= 1'b1;
                state_q     <= ST_EMIT;
              end
              default: sel_q <= M_RECALL;
            endcase
          end
        end
        ST_EMIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            k_q         <= k_q + 1'b1;
            if (k_q == CLS_W'(NUM_CLASSES - 1)) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_CLS_DIFF;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign class_index_o       = k_q;
  assign true_pos_o          = tp_q;
  assign false_pos_o         = fp_q;
  assign false_neg_o         = fn_q;
  assign recall_ratio_o      = recall_q;
  assign precision_ratio_o   = prec_q;
  assign f_score_o           = f1_q;
  assign specificity_ratio_o = spec_q;
  assign neg_pred_value_o    = npv_q;
  assign overall_accuracy_o  = acc_q;
  assign kappa_value_o       = kap_q;
  assign last_class_o        = (k_q == CLS_W'(NUM_CLASSES - 1));

  `CMM_ASSERT_SAME(a_no_input_while_out, out_valid_o, in_stall_o, "input open during output")
  `CMM_ASSERT_NEXT(a_gap_after_beat, out_valid_o && !out_stall_i, !out_valid_o, "no gap after beat")
  `CMM_ASSERT_NEXT(a_idle_after_last, out_valid_o && !out_stall_i && last_class_o, !in_stall_o, "not idle after run")
  `CMM_ASSERT_SAME(a_recall_le_one, out_valid_o, recall_ratio_o <= (RATIO_W'(1) << FRAC_BITS), "ratio above one")

endmodule
